// ===== rtl/fqp_pkg.sv =====
// ----------------------------------------------------------------------------
// fqp_pkg: shared types and constants for the promote-to-front FIFO
// Queue geometry, opcodes, status codes and the IEEE single equality test.
// ----------------------------------------------------------------------------
package fqp_pkg;

	// Queue geometry (depth must stay a power of two for ring wraparound)
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;

	// Item field widths
	localparam int VAL_W  = 32;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;

	// Stream data widths, padded to whole bytes
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 40;

	localparam logic [VAL_W-1:0] MINUS_ONE_PATTERN = 32'hBF80_0000;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_REMOVE  = 2'd1,
		OP_PROMOTE = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// NaN: exponent all ones, mantissa nonzero
	function automatic logic is_nan(input logic [VAL_W-1:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction

	// IEEE equality: +0 == -0, NaN never equal
	function automatic logic ieee_equal(input logic [VAL_W-1:0] a,
	                                    input logic [VAL_W-1:0] b);
		logic res;
		if (is_nan(a) || is_nan(b)) begin
			res = 1'b0;
		end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
			res = 1'b1;
		end else begin
			res = (a == b);
		end
		return res;
	endfunction

	// Physical slot of the k-th entry from the head
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
	                                             input logic [IDX_W-1:0] k);
		logic [IDX_W:0] sum;
		sum = {1'b0, head} + {1'b0, k};
		return sum[IDX_W-1:0];
	endfunction

endpackage

// ===== rtl/fifo_queue_with_promote_to_front.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_promote_to_front: bounded float FIFO with promote-to-front
// Ring buffer of IEEE single patterns with insert, remove and promote.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item per operation, opcode on s_tuser, value on
//   s_tdata. Output channel m_*: exactly one result item per input item,
//   status on m_tuser, removed value and occupancy on m_tdata.
//   Items are handled one at a time; s_tready is high only while the
//   sequencer is idle. Insert and unused opcodes go straight to the result
//   step; remove adds one registered memory read. Promote on an empty or
//   one-entry queue goes straight to the result; otherwise the scan reads,
//   then compares, each entry inspected, and a match at position p shifts
//   the p entries ahead of it down one slot and then writes the match at the
//   head. This work is serial, set by the single read and single write port
//   of the entry memory.
//   Reset empties the queue (head and count cleared); stored entries are
//   not cleared and are never read before being written.
//   A finished result sits in the output register; the next item is accepted
//   while it waits, and its own result waits until m_tready frees the slot.
module fifo_queue_with_promote_to_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [fqp_pkg::S_DATA_W-1:0]   s_tdata,  // [31:0] value
	input  logic [fqp_pkg::OP_W-1:0]       s_tuser,  // [1:0] opcode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [fqp_pkg::M_DATA_W-1:0]   m_tdata,  // [31:0] removed_value, [36:32] occupancy
	output logic [fqp_pkg::STAT_W-1:0]     m_tuser   // [1:0] status
);
	import fqp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_FRONT,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic [VAL_W-1:0]   key_q;
	logic [VAL_W-1:0]   found_q;
	logic [VAL_W-1:0]   res_val_q;
	status_t            res_stat_q;

	logic               m_valid_q;
	logic [VAL_W-1:0]   m_val_q;
	logic [CNT_W-1:0]   m_occ_q;
	status_t            m_stat_q;

	// Entry memory: one write port, one registered read port
	logic [VAL_W-1:0]   mem [QUEUE_DEPTH];
	logic [VAL_W-1:0]   rdata_q;
	logic [IDX_W-1:0]   raddr;
	logic [IDX_W-1:0]   waddr;
	logic [VAL_W-1:0]   wdata;
	logic               we;

	logic               accept;
	logic               full;
	logic               last_idx;
	logic               out_free;
	opcode_t            op_in;
	logic [VAL_W-1:0]   val_in;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign last_idx = ({1'b0, idx_q} == (count_q - CNT_W'(1)));
	assign out_free = !m_valid_q || m_tready;
	assign op_in    = opcode_t'(s_tuser);
	assign val_in   = s_tdata[VAL_W-1:0];

	// Read address per state
	always_comb begin
		case (state_q)
			S_SCAN_RD:  raddr = slot_of(head_q, idx_q);
			S_SHIFT_RD: raddr = slot_of(head_q, idx_q - IDX_W'(1));
			default:    raddr = head_q;
		endcase
	end

	// Write port per state
	always_comb begin
		we    = 1'b0;
		waddr = head_q;
		wdata = rdata_q;
		case (state_q)
			S_IDLE: begin
				we    = accept && (op_in == OP_INSERT) && !full;
				waddr = slot_of(head_q, count_q[IDX_W-1:0]);
				wdata = val_in;
			end
			S_SHIFT_WR: begin
				we    = 1'b1;
				waddr = slot_of(head_q, idx_q);
				wdata = rdata_q;
			end
			S_FRONT: begin
				we    = 1'b1;
				waddr = head_q;
				wdata = found_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Memory array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			key_q      <= '0;
			found_q    <= '0;
			res_val_q  <= '0;
			res_stat_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q <= val_in;
						idx_q <= '0;
						case (op_in)
							OP_INSERT: begin
								res_val_q <= '0;
								state_q   <= S_DONE;
								if (full) begin
									res_stat_q <= ST_FULL;
								end else begin
									res_stat_q <= ST_OK;
									count_q    <= count_q + CNT_W'(1);
								end
							end
							OP_REMOVE: begin
								if (count_q == '0) begin
									res_val_q  <= MINUS_ONE_PATTERN;
									res_stat_q <= ST_EMPTY;
									state_q    <= S_DONE;
								end else begin
									res_val_q  <= '0;
									res_stat_q <= ST_OK;
									state_q    <= S_POP;
								end
							end
							OP_PROMOTE: begin
								res_val_q <= '0;
								if (count_q == '0) begin
									res_stat_q <= ST_EMPTY;
									state_q    <= S_DONE;
								end else if (count_q == CNT_W'(1)) begin
									res_stat_q <= ST_OK;
									state_q    <= S_DONE;
								end else begin
									res_stat_q <= ST_OK;
									state_q    <= S_SCAN_RD;
								end
							end
							default: begin
								res_val_q  <= '0;
								res_stat_q <= ST_OK;
								state_q    <= S_DONE;
							end
						endcase
					end
				end
				// head entry read in the accept cycle
				S_POP: begin
					res_val_q <= rdata_q;
					head_q    <= slot_of(head_q, IDX_W'(1));
					count_q   <= count_q - CNT_W'(1);
					state_q   <= S_DONE;
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				// compare entry idx_q against the key
				S_SCAN_CMP: begin
					if (ieee_equal(rdata_q, key_q)) begin
						found_q <= rdata_q;
						state_q <= (idx_q == '0) ? S_DONE : S_SHIFT_RD;
					end else if (last_idx) begin
						res_stat_q <= ST_NOT_FOUND;
						state_q    <= S_DONE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				// entry k-1 moves into slot k
				S_SHIFT_WR: begin
					if (idx_q == IDX_W'(1)) begin
						state_q <= S_FRONT;
					end else begin
						idx_q   <= idx_q - IDX_W'(1);
						state_q <= S_SHIFT_RD;
					end
				end
				S_FRONT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_val_q   <= '0;
			m_occ_q   <= '0;
			m_stat_q  <= ST_OK;
		end else begin
			if (state_q == S_DONE && out_free) begin
				m_valid_q <= 1'b1;
				m_val_q   <= res_val_q;
				m_stat_q  <= res_stat_q;
				m_occ_q   <= count_q;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(M_DATA_W - VAL_W - CNT_W)'(0), m_occ_q, m_val_q};
	assign m_tuser  = m_stat_q;

endmodule

// ===== rtl/fqp_checker.sv =====
// ----------------------------------------------------------------------------
// fqp_checker: port-level assertions for the promote-to-front FIFO
// Watches the stream ports and checks result consistency over time.
// ----------------------------------------------------------------------------
module fqp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [fqp_pkg::M_DATA_W-1:0]   m_tdata,
	input logic [fqp_pkg::STAT_W-1:0]     m_tuser
);
	import fqp_pkg::*;

	logic [CNT_W-1:0] occ;
	assign occ = m_tdata[VAL_W+CNT_W-1:VAL_W];

	// one item at a time: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted back to back");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	// occupancy never exceeds depth
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (occ <= CNT_W'(QUEUE_DEPTH)))
		else $error("occupancy out of range");

	// full status only on a full queue
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_FULL) |-> (occ == CNT_W'(QUEUE_DEPTH)))
		else $error("full reported below depth");

	// empty status only on an empty queue
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_EMPTY) |-> (occ == '0))
		else $error("empty reported with entries held");

endmodule

bind fifo_queue_with_promote_to_front fqp_checker u_fqp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
